FILE: rtl/onenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package onenc_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int MAG_W          = COMPONENT_BITS;       // |-2^(N-1)| still fits N bits unsigned
    localparam int SUM_W          = COMPONENT_BITS + 1;   // 3 * 2^(N-1) < 2^(N+1)
    localparam int SCALE_W        = 15;
    localparam int PROD_W         = SUM_W + SCALE_W;
    localparam int QUO_W          = 15;                   // quotient never exceeds the scale
    localparam int OUT_W          = 16;

    localparam logic [SCALE_W-1:0] SCALE_8BIT  = 15'd127;
    localparam logic [SCALE_W-1:0] SCALE_16BIT = 15'd32512;

    localparam logic MODE_8BIT  = 1'b0;
    localparam logic MODE_16BIT = 1'b1;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] normal_x;
        logic signed [COMPONENT_BITS-1:0] normal_y;
        logic signed [COMPONENT_BITS-1:0] normal_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] encoded_u;
        logic signed [OUT_W-1:0] encoded_v;
        logic                    zero_vector;
    } t_out_item;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] az;
        logic             nx;
        logic             ny;
        logic             nz;
    } t_mag_data;

    typedef struct packed {
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] nu;
        logic [SUM_W-1:0] nv;
        logic             neg_u;
        logic             neg_v;
        logic             zero;
    } t_num_data;

    typedef struct packed {
        logic [SUM_W-1:0]  s;
        logic [PROD_W-1:0] rem_u;
        logic [PROD_W-1:0] rem_v;
        logic [QUO_W-1:0]  q_u;
        logic [QUO_W-1:0]  q_v;
        logic              neg_u;
        logic              neg_v;
        logic              zero;
    } t_div_data;

    function automatic logic [MAG_W-1:0] abs_mag(input logic [COMPONENT_BITS-1:0] x);
        logic [MAG_W-1:0] v;
        v = MAG_W'(x);
        return x[COMPONENT_BITS-1] ? (~v + MAG_W'(1)) : v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/onenc_prep.sv
`timescale 1ns / 1ps
`default_nettype none

// Two stages: magnitudes and signs, then sum and the numerators.
module onenc_prep
    import onenc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_num_data      o_num
);

    logic      r_mag_valid;
    t_mag_data r_mag;
    t_mag_data n_mag;
    logic      r_num_valid;
    t_num_data r_num;
    t_num_data n_num;
    logic      num_ready;

    assign num_ready = !r_num_valid || i_ready;
    assign o_ready   = !r_mag_valid || num_ready;

    always_comb begin
        n_mag.ax = abs_mag(i_item.normal_x);
        n_mag.ay = abs_mag(i_item.normal_y);
        n_mag.az = abs_mag(i_item.normal_z);
        n_mag.nx = i_item.normal_x[COMPONENT_BITS-1];
        n_mag.ny = i_item.normal_y[COMPONENT_BITS-1];
        n_mag.nz = i_item.normal_z[COMPONENT_BITS-1];
    end

    // Folded half: (1-|v|)*s = |x|+|z|, (1-|u|)*s = |y|+|z|
    always_comb begin
        n_num.s     = SUM_W'(r_mag.ax) + SUM_W'(r_mag.ay) + SUM_W'(r_mag.az);
        n_num.nu    = r_mag.nz ? (SUM_W'(r_mag.ax) + SUM_W'(r_mag.az)) : SUM_W'(r_mag.ax);
        n_num.nv    = r_mag.nz ? (SUM_W'(r_mag.ay) + SUM_W'(r_mag.az)) : SUM_W'(r_mag.ay);
        n_num.neg_u = r_mag.nx;
        n_num.neg_v = r_mag.ny;
        n_num.zero  = (r_mag.ax | r_mag.ay | r_mag.az) == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_valid <= 1'b0;
            r_num_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_mag_valid <= i_valid;
            end
            if (num_ready) begin
                r_num_valid <= r_mag_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= n_mag;
        end
        if (num_ready && r_mag_valid) begin
            r_num <= n_num;
        end
    end

    assign o_valid = r_num_valid;
    assign o_num   = r_num;

endmodule

`default_nettype wire

FILE: rtl/onenc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Scales both numerators; the products become the dividends.
module onenc_mul
    import onenc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_precision_mode,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_num_data i_num,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_data      o_div
);

    logic               r_valid;
    t_div_data          r_div;
    t_div_data          n_div;
    logic [SCALE_W-1:0] scale;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        unique case (i_precision_mode)
            MODE_16BIT: scale = SCALE_16BIT;
            default:    scale = SCALE_8BIT;
        endcase
    end

    always_comb begin
        n_div.s     = i_num.s;
        n_div.rem_u = PROD_W'(i_num.nu) * PROD_W'(scale);
        n_div.rem_v = PROD_W'(i_num.nv) * PROD_W'(scale);
        n_div.q_u   = '0;
        n_div.q_v   = '0;
        n_div.neg_u = i_num.neg_u;
        n_div.neg_v = i_num.neg_v;
        n_div.zero  = i_num.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

`default_nettype wire

FILE: rtl/onenc_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step for both coordinates: quotient bit BIT_POS.
module onenc_div_stage
    import onenc_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_data i_div,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_data      o_div
);

    logic              r_valid;
    t_div_data         r_div;
    t_div_data         n_div;
    logic [PROD_W-1:0] divisor;
    logic              ge_u;
    logic              ge_v;

    assign o_ready = !r_valid || i_ready;
    assign divisor = PROD_W'(i_div.s) << BIT_POS;
    assign ge_u    = i_div.rem_u >= divisor;
    assign ge_v    = i_div.rem_v >= divisor;

    always_comb begin
        n_div              = i_div;
        n_div.rem_u        = ge_u ? (i_div.rem_u - divisor) : i_div.rem_u;
        n_div.rem_v        = ge_v ? (i_div.rem_v - divisor) : i_div.rem_v;
        n_div.q_u[BIT_POS] = ge_u;
        n_div.q_v[BIT_POS] = ge_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

`default_nettype wire

FILE: rtl/octahedral_normal_encoder_unit.sv
// Octahedral normal encoder.
// Input channel (i_in_valid / o_in_ready, payload i_in_data): one normal vector
// of three signed components per transaction. Output channel (o_out_valid /
// i_out_ready, payload o_out_data): the two octahedral coordinates scaled by
// 127 or 32512, truncated toward zero, plus a flag for the all-zero vector.
// i_cfg_wr_en / i_cfg_wr_data write the precision mode (0: 8-bit scale,
// 1: 16-bit scale); write it only while the pipeline is empty.
// Pipeline: magnitudes, sum, scale multiply, 15 restoring-division steps (one
// quotient bit each) and the output register. One transaction per cycle is
// sustained while the receiver does not stall.
// The 15-bit quotient sets the number of division steps, one compare and subtract per stage.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up. When the receiver stalls, the output
// holds and the stages behind it fill; o_in_ready falls only once all are full.
// Synchronous reset empties the pipeline and returns the mode to 8-bit.
`timescale 1ns / 1ps
`default_nettype none

module octahedral_normal_encoder_unit
    import onenc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_wr_en,
    input  wire logic      i_cfg_wr_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic      r_precision_mode;
    logic      num_valid;
    logic      num_ready;
    t_num_data num_data;

    logic      div_valid [QUO_W+1];
    logic      div_ready [QUO_W+1];
    t_div_data div_data  [QUO_W+1];

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision_mode <= MODE_8BIT;
        end else if (i_cfg_wr_en) begin
            r_precision_mode <= i_cfg_wr_data;
        end
    end

    onenc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (num_valid),
        .i_ready (num_ready),
        .o_num   (num_data)
    );

    onenc_mul u_mul (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_precision_mode (r_precision_mode),
        .i_valid          (num_valid),
        .o_ready          (num_ready),
        .i_num            (num_data),
        .o_valid          (div_valid[0]),
        .i_ready          (div_ready[0]),
        .o_div            (div_data[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        onenc_div_stage #(
            .BIT_POS (QUO_W - 1 - k)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[k]),
            .o_ready (div_ready[k]),
            .i_div   (div_data[k]),
            .o_valid (div_valid[k+1]),
            .i_ready (div_ready[k+1]),
            .o_div   (div_data[k+1])
        );
    end

    assign div_ready[QUO_W] = !r_out_valid || i_out_ready;
    assign out_load         = div_ready[QUO_W] && div_valid[QUO_W];

    // Zero vector runs through the divider with s = 0; its quotient is discarded.
    always_comb begin
        n_out.zero_vector = div_data[QUO_W].zero;
        if (div_data[QUO_W].zero) begin
            n_out.encoded_u = '0;
            n_out.encoded_v = '0;
        end else begin
            n_out.encoded_u = div_data[QUO_W].neg_u ? -OUT_W'(div_data[QUO_W].q_u)
                                                    :  OUT_W'(div_data[QUO_W].q_u);
            n_out.encoded_v = div_data[QUO_W].neg_v ? -OUT_W'(div_data[QUO_W].q_v)
                                                    :  OUT_W'(div_data[QUO_W].q_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_ready[QUO_W]) begin
            r_out_valid <= div_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/onenc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module onenc_checker
    import onenc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_zero_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_vector |->
            o_out_data.encoded_u == '0 && o_out_data.encoded_v == '0)
        else $error("zero vector with nonzero coordinates");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.encoded_u <= 16'sd32512 && o_out_data.encoded_u >= -16'sd32512 &&
            o_out_data.encoded_v <= 16'sd32512 && o_out_data.encoded_v >= -16'sd32512)
        else $error("coordinate beyond full scale");

endmodule

bind octahedral_normal_encoder_unit onenc_checker u_onenc_checker (.*);

`default_nettype wire
